### hdl/secs_pkg.sv
package secs_pkg;

    // host and device item actions
    typedef enum logic [2:0] {
        ACT_WRITE  = 3'd0,
        ACT_READ   = 3'd1,
        ACT_DEVICE = 3'd2,
        ACT_SLEEP  = 3'd3,
        ACT_WAKE   = 3'd4
    } action_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_SEND    = 3'd0,
        KIND_CLOCK   = 3'd1,
        KIND_RELEASE = 3'd2,
        KIND_HOST    = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    // sequencer phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_POLL   = 5'b00010,
        PH_OPEN   = 5'b00100,
        PH_PAUSED = 5'b01000,
        PH_READ   = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_SLEEP = 2'd2
    } op_t;

    // frame sequences the back end can play
    typedef enum logic [3:0] {
        SEQ_ERROR  = 4'd0,
        SEQ_WAKE   = 4'd1,
        SEQ_POLL   = 4'd2,
        SEQ_REPOLL = 4'd3,
        SEQ_WRITE  = 4'd4,
        SEQ_READ   = 4'd5,
        SEQ_SLEEP  = 4'd6,
        SEQ_STREAM = 4'd7,
        SEQ_RDATA  = 4'd8
    } seq_t;

    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_WRITE  = 8'h02;
    localparam logic [7:0] CMD_WREN   = 8'h06;
    localparam logic [7:0] CMD_RDSR   = 8'h05;
    localparam logic [7:0] CMD_SLEEP  = 8'hB9;
    localparam logic [7:0] CMD_WAKE   = 8'hAB;
    localparam logic [7:0] STATUS_WIP = 8'h01;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int STEP_W      = 3;

    typedef struct packed {
        seq_t        seq;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        close;
    } job_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       host_last;
        logic       run_end;
    } result_t;

endpackage

### hdl/secs_queue.sv
module secs_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  secs_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output secs_pkg::job_t head_job,
    output logic          empty
);
    import secs_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hdl/secs_front.sv
module secs_front #(
    parameter int PAGE_BYTES = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [2:0]     s_action,
    input  logic [15:0]    s_address,
    input  logic [7:0]     s_data,
    input  logic           s_last,
    input  logic [15:0]    s_read_count,
    output logic           job_push,
    output secs_pkg::job_t job,
    input  logic           queue_full
);
    import secs_pkg::*;

    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int RECIP_W = 24 - $clog2(PAGE_BYTES) + 1;
    localparam int PROD_W  = 16 + RECIP_W;
    localparam logic [PROD_W-1:0] RECIP  = PROD_W'((1 << 24) / PAGE_BYTES);
    localparam logic [15:0]       PAGE16 = 16'(PAGE_BYTES);
    localparam logic [OFF_W-1:0]  OFF_MAX = OFF_W'(PAGE_BYTES - 1);

    phase_t             phase_reg, phase_next;
    op_t                op_reg, op_next;
    logic [15:0]        addr_reg, addr_next;
    logic [7:0]         pend_data_reg, pend_data_next;
    logic               pend_last_reg, pend_last_next;
    logic [15:0]        rem_reg, rem_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [1:0]         mod_cnt_reg, mod_cnt_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [15:0]        qp_reg;

    logic [15:0]        mod_diff;
    logic [15:0]        mod_rem;
    logic [OFF_W-1:0]   off_inc;
    logic               boundary;
    action_t            action;

    assign action   = action_t'(s_action);
    assign s_tready = !queue_full && (mod_cnt_reg == 2'd0);
    assign job_push = s_tvalid && s_tready;

    // page offset after one more byte, with the 16-bit address wrap restarting a page
    assign off_inc  = ((addr_reg == 16'hFFFF) || (off_reg == OFF_MAX)) ? '0 : off_reg + 1'b1;
    assign boundary = (off_inc == '0);

    // last step of the offset reduction: one compare and subtract
    assign mod_diff = addr_reg - qp_reg;
    assign mod_rem  = (mod_diff >= PAGE16) ? mod_diff - PAGE16 : mod_diff;

    always_comb begin
        phase_next     = phase_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        pend_data_next = pend_data_reg;
        pend_last_next = pend_last_reg;
        rem_next       = rem_reg;
        off_next       = off_reg;
        mod_cnt_next   = (mod_cnt_reg != 2'd0) ? mod_cnt_reg - 1'b1 : 2'd0;
        job.seq        = SEQ_ERROR;
        job.addr       = addr_reg;
        job.data       = s_data;
        job.close      = 1'b0;

        if (mod_cnt_reg == 2'd1) begin
            off_next = OFF_W'(mod_rem);
        end

        if (job_push) begin
            case (action)
                ACT_WRITE: begin
                    if (phase_reg == PH_IDLE || phase_reg == PH_PAUSED) begin
                        if (phase_reg == PH_IDLE) begin
                            addr_next    = s_address;
                            mod_cnt_next = 2'd3;
                        end
                        pend_data_next = s_data;
                        pend_last_next = s_last;
                        op_next        = OP_WRITE;
                        phase_next     = PH_POLL;
                        job.seq        = SEQ_POLL;
                    end else if (phase_reg == PH_OPEN) begin
                        job.seq   = SEQ_STREAM;
                        job.close = s_last || boundary;
                        addr_next = addr_reg + 1'b1;
                        off_next  = off_inc;
                        phase_next = s_last ? PH_IDLE : (boundary ? PH_PAUSED : PH_OPEN);
                    end
                end
                ACT_READ: begin
                    if (phase_reg == PH_IDLE) begin
                        addr_next  = s_address;
                        rem_next   = s_read_count;
                        op_next    = OP_READ;
                        phase_next = PH_POLL;
                        job.seq    = SEQ_POLL;
                    end
                end
                ACT_DEVICE: begin
                    if (phase_reg == PH_POLL) begin
                        if ((s_data & STATUS_WIP) != 8'h00) begin
                            job.seq = SEQ_REPOLL;
                        end else begin
                            case (op_reg)
                                OP_WRITE: begin
                                    job.seq    = SEQ_WRITE;
                                    job.data   = pend_data_reg;
                                    job.close  = pend_last_reg || boundary;
                                    addr_next  = addr_reg + 1'b1;
                                    off_next   = off_inc;
                                    phase_next = pend_last_reg ? PH_IDLE :
                                                 (boundary ? PH_PAUSED : PH_OPEN);
                                end
                                OP_READ: begin
                                    job.seq    = SEQ_READ;
                                    job.close  = (rem_reg == 16'd0);
                                    phase_next = (rem_reg == 16'd0) ? PH_IDLE : PH_READ;
                                end
                                default: begin
                                    job.seq    = SEQ_SLEEP;
                                    phase_next = PH_IDLE;
                                end
                            endcase
                        end
                    end else if (phase_reg == PH_READ) begin
                        job.seq   = SEQ_RDATA;
                        job.close = (rem_reg == 16'd1);
                        rem_next  = rem_reg - 1'b1;
                        if (rem_reg == 16'd1) begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                ACT_SLEEP: begin
                    if (phase_reg == PH_IDLE) begin
                        op_next    = OP_SLEEP;
                        phase_next = PH_POLL;
                        job.seq    = SEQ_POLL;
                    end
                end
                ACT_WAKE: begin
                    if (phase_reg == PH_IDLE) begin
                        job.seq = SEQ_WAKE;
                    end
                end
                default: begin
                    job.seq = SEQ_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            op_reg        <= OP_WRITE;
            addr_reg      <= '0;
            pend_data_reg <= '0;
            pend_last_reg <= 1'b0;
            rem_reg       <= '0;
            off_reg       <= '0;
            mod_cnt_reg   <= 2'd0;
        end else begin
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            pend_data_reg <= pend_data_next;
            pend_last_reg <= pend_last_next;
            rem_reg       <= rem_next;
            off_reg       <= off_next;
            mod_cnt_reg   <= mod_cnt_next;
        end
    end

    // page offset of a fresh write address: reciprocal multiply, then back-multiply
    always_ff @(posedge aclk) begin
        if (mod_cnt_reg == 2'd3) begin
            prod_reg <= PROD_W'(addr_reg) * RECIP;
        end
        if (mod_cnt_reg == 2'd2) begin
            qp_reg <= 16'(prod_reg[PROD_W-1:24]) * PAGE16;
        end
    end

`ifndef SYNTHESIS
    a_open_is_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_OPEN || phase_reg == PH_PAUSED) |-> op_reg == OP_WRITE)
        else $error("write frame phase without a pending write");

    a_read_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_READ) |-> rem_reg != 16'd0)
        else $error("read phase with no bytes left");

    a_no_push_while_reducing: assert property (@(posedge aclk) disable iff (!aresetn)
        (mod_cnt_reg != 2'd0) |-> !job_push)
        else $error("item taken before page offset was ready");
`endif

endmodule

### hdl/secs_back.sv
module secs_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  secs_pkg::job_t head_job,
    input  logic           queue_empty,
    output logic           job_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic [3:0]     m_tuser
);
    import secs_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    result_t           res_reg;
    result_t           res;
    logic              advance;

    assign advance = !queue_empty && (!valid_reg || m_tready);

    // one frame event per step of the current sequence
    always_comb begin
        res.kind      = KIND_SEND;
        res.out_byte  = 8'h00;
        res.host_last = 1'b0;
        res.run_end   = 1'b0;
        case (head_job.seq)
            SEQ_WAKE: begin
                case (step_reg)
                    3'd0: res.out_byte = CMD_WAKE;
                    default: begin
                        res.kind = KIND_RELEASE; res.run_end = 1'b1;
                    end
                endcase
            end
            SEQ_POLL: begin
                case (step_reg)
                    3'd0: res.out_byte = CMD_RDSR;
                    default: begin
                        res.kind = KIND_CLOCK; res.run_end = 1'b1;
                    end
                endcase
            end
            SEQ_REPOLL: begin
                case (step_reg)
                    3'd0: res.kind = KIND_RELEASE;
                    3'd1: res.out_byte = CMD_RDSR;
                    default: begin
                        res.kind = KIND_CLOCK; res.run_end = 1'b1;
                    end
                endcase
            end
            SEQ_WRITE: begin
                case (step_reg)
                    3'd0: res.kind = KIND_RELEASE;
                    3'd1: res.out_byte = CMD_WREN;
                    3'd2: res.kind = KIND_RELEASE;
                    3'd3: res.out_byte = CMD_WRITE;
                    3'd4: res.out_byte = head_job.addr[15:8];
                    3'd5: res.out_byte = head_job.addr[7:0];
                    3'd6: begin
                        res.out_byte = head_job.data; res.run_end = !head_job.close;
                    end
                    default: begin
                        res.kind = KIND_RELEASE; res.run_end = 1'b1;
                    end
                endcase
            end
            SEQ_READ: begin
                case (step_reg)
                    3'd0: res.kind = KIND_RELEASE;
                    3'd1: res.out_byte = CMD_READ;
                    3'd2: res.out_byte = head_job.addr[15:8];
                    3'd3: res.out_byte = head_job.addr[7:0];
                    default: begin
                        res.kind    = head_job.close ? KIND_RELEASE : KIND_CLOCK;
                        res.run_end = 1'b1;
                    end
                endcase
            end
            SEQ_SLEEP: begin
                case (step_reg)
                    3'd0: res.kind = KIND_RELEASE;
                    3'd1: res.out_byte = CMD_SLEEP;
                    default: begin
                        res.kind = KIND_RELEASE; res.run_end = 1'b1;
                    end
                endcase
            end
            SEQ_STREAM: begin
                case (step_reg)
                    3'd0: begin
                        res.out_byte = head_job.data; res.run_end = !head_job.close;
                    end
                    default: begin
                        res.kind = KIND_RELEASE; res.run_end = 1'b1;
                    end
                endcase
            end
            SEQ_RDATA: begin
                case (step_reg)
                    3'd0: begin
                        res.kind      = KIND_HOST;
                        res.out_byte  = head_job.data;
                        res.host_last = head_job.close;
                    end
                    default: begin
                        res.kind    = head_job.close ? KIND_RELEASE : KIND_CLOCK;
                        res.run_end = 1'b1;
                    end
                endcase
            end
            default: begin
                res.kind    = KIND_ERROR;
                res.run_end = 1'b1;
            end
        endcase
    end

    assign job_pop = advance && res.run_end;

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
            step_next  = res.run_end ? '0 : step_reg + 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.out_byte;
    assign m_tlast  = res_reg.run_end;
    assign m_tuser  = {res_reg.host_last, res_reg.kind};

`ifndef SYNTHESIS
    a_error_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.kind == KIND_ERROR) |-> res_reg.run_end)
        else $error("error result not closing its run");

    a_host_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.host_last) |-> (res_reg.kind == KIND_HOST && !res_reg.run_end))
        else $error("host last flag on a wrong result");

    a_job_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != '0) |-> !queue_empty)
        else $error("sequence in progress with no job at queue head");
`endif

endmodule

### hdl/spi_eeprom_command_sequencer_unit.sv
// command sequencer for a 25-series spi eeprom
// input channel (s_): one host request or one byte returned by the device per transfer;
//   s_tuser carries the action, s_tlast marks the final byte of a write buffer
// output channel (m_): spi frame events and host read data, one event per transfer;
//   m_tlast marks the final event caused by one input item
// a front stage tracks the eeprom phase and turns each item into a frame sequence job,
// a four-entry job queue decouples it from the back stage that plays each job out
// with an empty queue, the first event of an item passes through the queue slot and then the output register
// throughput: one event per cycle while the receiver takes them, and an item gives 1 to 8 events
//   depending on its sequence; the front keeps taking items while the queue has room
// a write that opens a new stream from idle blocks the input while the
//   page offset of its address is worked out by a reciprocal multiply
// when the receiver stalls, the held event stays on m_ and the queue fills, after
//   which s_tready drops
// reset (aresetn low at a clock edge) returns the phase to idle, empties the queue
//   and drops m_tvalid
module spi_eeprom_command_sequencer_unit #(
    parameter int PAGE_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address [15:0], data [23:16], read_count [39:24]
    input  logic        s_tlast,   // last_byte
    input  logic [2:0]  s_tuser,   // action [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic        m_tlast,   // run_end
    output logic [3:0]  m_tuser    // out_kind [2:0], host_last [3]
);
    import secs_pkg::*;

    // jobs between front and back
    job_t push_job;
    job_t head_job;
    logic job_push;
    logic job_pop;
    logic queue_full;
    logic queue_empty;

    // front: phase tracking and classification
    secs_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_action     (s_tuser),
        .s_address    (s_tdata[15:0]),
        .s_data       (s_tdata[23:16]),
        .s_last       (s_tlast),
        .s_read_count (s_tdata[39:24]),
        .job_push     (job_push),
        .job          (push_job),
        .queue_full   (queue_full)
    );

    // short job queue
    secs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (queue_empty)
    );

    // back: frame event generation into the output register
    secs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_job    (head_job),
        .queue_empty (queue_empty),
        .job_pop     (job_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

### dv/tb_spi_eeprom_command_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_spi_eeprom_command_sequencer_unit;
    import secs_pkg::*;

    localparam int PAGE_BYTES = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_CAP = 40;
    localparam int RANDOM_PER_PHASE = 64;
    localparam int DRAIN_CYCLES = 20;

    // action codes the block has no use for, they must come back as errors
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    // one host request or device byte, as it travels on the input channel
    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [7:0]  data;
        logic        last_byte;
        logic [15:0] read_count;
    } eeprom_req_t;

    // sequencer state as the predictor tracks it
    typedef struct {
        phase_t      ph;
        op_t         op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        last;
        logic [15:0] remaining;
    } seq_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    eeprom_req_t pending_reqs[$];     // requests waiting for the driver
    result_t     expected_frames[$];  // frame events still owed by the block
    seq_state_t  eeprom_shadow;       // state after every accepted transfer
    seq_state_t  plan_shadow;         // state the stimulus generator plans against
    int          reqs_queued = 0;
    int          reqs_accepted = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    logic        in_taken = 1'b0;

    spi_eeprom_command_sequencer_unit #(
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_state(output seq_state_t st);
        st.ph        = PH_IDLE;
        st.op        = OP_WRITE;
        st.addr      = '0;
        st.data      = '0;
        st.last      = 1'b0;
        st.remaining = '0;
    endfunction

    function automatic void add_frame(inout result_t q[$], input kind_t k,
                                      input logic [7:0] b, input logic hl);
        result_t f;
        f.kind      = k;
        f.out_byte  = b;
        f.host_last = hl;
        f.run_end   = 1'b0;
        q.push_back(f);
    endfunction

    // one data byte inside the open write frame; the frame closes on the
    // marked last byte or when the address crosses into a new page
    function automatic void stream_byte(inout seq_state_t st, inout result_t q[$],
                                        input logic [7:0] b, input logic lst);
        add_frame(q, KIND_SEND, b, 1'b0);
        st.addr = st.addr + 16'd1;
        if (lst) begin
            add_frame(q, KIND_RELEASE, 8'h00, 1'b0);
            st.ph = PH_IDLE;
        end else if (st.addr % PAGE_BYTES == 0) begin
            add_frame(q, KIND_RELEASE, 8'h00, 1'b0);
            st.ph = PH_PAUSED;
        end else begin
            st.ph = PH_OPEN;
        end
    endfunction

    // frame events caused by one accepted request, state advanced in place
    function automatic void predict_frames(inout seq_state_t st, input eeprom_req_t it,
                                           output result_t q[$]);
        logic fault;
        fault = 1'b0;
        q = {};
        case (it.action)
            ACT_WRITE: begin
                if (st.ph == PH_IDLE || st.ph == PH_PAUSED) begin
                    // a paused stream keeps its own address
                    if (st.ph == PH_IDLE) st.addr = it.address;
                    st.data = it.data;
                    st.last = it.last_byte;
                    st.op   = OP_WRITE;
                    add_frame(q, KIND_SEND, CMD_RDSR, 1'b0);
                    add_frame(q, KIND_CLOCK, 8'h00, 1'b0);
                    st.ph = PH_POLL;
                end else if (st.ph == PH_OPEN) begin
                    stream_byte(st, q, it.data, it.last_byte);
                end else begin
                    fault = 1'b1;
                end
            end
            ACT_READ: begin
                if (st.ph == PH_IDLE) begin
                    st.addr      = it.address;
                    st.remaining = it.read_count;
                    st.op        = OP_READ;
                    add_frame(q, KIND_SEND, CMD_RDSR, 1'b0);
                    add_frame(q, KIND_CLOCK, 8'h00, 1'b0);
                    st.ph = PH_POLL;
                end else begin
                    fault = 1'b1;
                end
            end
            ACT_DEVICE: begin
                if (st.ph == PH_POLL) begin
                    add_frame(q, KIND_RELEASE, 8'h00, 1'b0);
                    if (it.data & STATUS_WIP) begin
                        add_frame(q, KIND_SEND, CMD_RDSR, 1'b0);
                        add_frame(q, KIND_CLOCK, 8'h00, 1'b0);
                    end else if (st.op == OP_WRITE) begin
                        add_frame(q, KIND_SEND, CMD_WREN, 1'b0);
                        add_frame(q, KIND_RELEASE, 8'h00, 1'b0);
                        add_frame(q, KIND_SEND, CMD_WRITE, 1'b0);
                        add_frame(q, KIND_SEND, st.addr[15:8], 1'b0);
                        add_frame(q, KIND_SEND, st.addr[7:0], 1'b0);
                        stream_byte(st, q, st.data, st.last);
                    end else if (st.op == OP_READ) begin
                        add_frame(q, KIND_SEND, CMD_READ, 1'b0);
                        add_frame(q, KIND_SEND, st.addr[15:8], 1'b0);
                        add_frame(q, KIND_SEND, st.addr[7:0], 1'b0);
                        if (st.remaining == 16'd0) begin
                            add_frame(q, KIND_RELEASE, 8'h00, 1'b0);
                            st.ph = PH_IDLE;
                        end else begin
                            add_frame(q, KIND_CLOCK, 8'h00, 1'b0);
                            st.ph = PH_READ;
                        end
                    end else begin
                        add_frame(q, KIND_SEND, CMD_SLEEP, 1'b0);
                        add_frame(q, KIND_RELEASE, 8'h00, 1'b0);
                        st.ph = PH_IDLE;
                    end
                end else if (st.ph == PH_READ) begin
                    add_frame(q, KIND_HOST, it.data, st.remaining == 16'd1);
                    st.remaining = st.remaining - 16'd1;
                    if (st.remaining != 16'd0) begin
                        add_frame(q, KIND_CLOCK, 8'h00, 1'b0);
                    end else begin
                        add_frame(q, KIND_RELEASE, 8'h00, 1'b0);
                        st.ph = PH_IDLE;
                    end
                end else begin
                    fault = 1'b1;
                end
            end
            ACT_SLEEP: begin
                if (st.ph == PH_IDLE) begin
                    st.op = OP_SLEEP;
                    add_frame(q, KIND_SEND, CMD_RDSR, 1'b0);
                    add_frame(q, KIND_CLOCK, 8'h00, 1'b0);
                    st.ph = PH_POLL;
                end else begin
                    fault = 1'b1;
                end
            end
            ACT_WAKE: begin
                if (st.ph == PH_IDLE) begin
                    add_frame(q, KIND_SEND, CMD_WAKE, 1'b0);
                    add_frame(q, KIND_RELEASE, 8'h00, 1'b0);
                end else begin
                    fault = 1'b1;
                end
            end
            default: fault = 1'b1;
        endcase
        // a misplaced item leaves the state alone and gives one error event
        if (fault) begin
            q = {};
            add_frame(q, KIND_ERROR, 8'h00, 1'b0);
        end
        q[q.size() - 1].run_end = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < PRINT_CAP)
            $display("mismatch: %s got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    // queue one request and advance the planning copy of the state
    task automatic queue_req(input logic [2:0] act, input logic [15:0] addr,
                             input logic [7:0] data, input logic lst,
                             input logic [15:0] cnt);
        eeprom_req_t it;
        result_t     dummy[$];
        it.action     = act;
        it.address    = addr;
        it.data       = data;
        it.last_byte  = lst;
        it.read_count = cnt;
        predict_frames(plan_shadow, it, dummy);
        pending_reqs.push_back(it);
        reqs_queued++;
    endtask

    // picks a request that fits the planned phase, with some noise mixed in
    task automatic queue_random_req();
        logic [2:0]  act;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        lst;
        logic [15:0] cnt;
        int          pick;
        addr = 16'($urandom);
        data = 8'($urandom);
        lst  = 1'b0;
        cnt  = 16'($urandom_range(0, 6));
        act  = ACT_WRITE;
        if ($urandom_range(0, 9) == 0) begin
            // noise: any action, any field; a stray read from idle stays short
            act  = 3'($urandom_range(0, 7));
            lst  = 1'($urandom);
            cnt  = 16'($urandom);
            if (plan_shadow.ph == PH_IDLE && act == ACT_READ) cnt = 16'($urandom_range(0, 3));
        end else begin
            case (plan_shadow.ph)
                PH_IDLE: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4) begin
                        act = ACT_WRITE;
                        lst = ($urandom_range(0, 4) == 0);
                        // start near a page end so streams cross pages often
                        if ($urandom_range(0, 1) == 0) addr[5:0] = 6'($urandom_range(56, 63));
                    end else if (pick < 7) begin
                        act = ACT_READ;
                        if ($urandom_range(0, 7) == 0) cnt = 16'($urandom_range(7, 70));
                    end else if (pick < 9) begin
                        act = ACT_SLEEP;
                    end else begin
                        act = ACT_WAKE;
                    end
                end
                PH_POLL: begin
                    act     = ACT_DEVICE;
                    data[0] = ($urandom_range(0, 9) < 3);  // device still busy
                end
                PH_OPEN, PH_PAUSED: begin
                    act = ACT_WRITE;
                    lst = ($urandom_range(0, 5) == 0);
                end
                default: act = ACT_DEVICE;
            endcase
        end
        queue_req(act, addr, data, lst, cnt);
    endtask

    // ------------------------------------------------------------------
    // driver: inputs change on the falling edge
    // ------------------------------------------------------------------

    always @(negedge aclk) begin : drive
        eeprom_req_t nxt;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.read_count, nxt.data, nxt.address};
                s_tlast  <= nxt.last_byte;
                s_tuser  <= nxt.action;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // monitor: both channels sampled on the rising edge
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : watch
        eeprom_req_t req;
        result_t     want;
        result_t     frames[$];
        if (aresetn) begin
            in_taken <= s_tvalid && s_tready;
            // compare a transfer on the result side with the oldest expectation
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("event with nothing expected, kind",
                                    int'(m_tuser[2:0]), 0);
                end else begin
                    want = expected_frames.pop_front();
                    if (m_tuser[2:0] !== want.kind)
                        report_mismatch("out_kind", int'(m_tuser[2:0]), int'(want.kind));
                    if (m_tdata !== want.out_byte)
                        report_mismatch("out_byte", int'(m_tdata), int'(want.out_byte));
                    if (m_tuser[3] !== want.host_last)
                        report_mismatch("host_last", int'(m_tuser[3]), int'(want.host_last));
                    if (m_tlast !== want.run_end)
                        report_mismatch("run_end", int'(m_tlast), int'(want.run_end));
                end
            end
            // accepted request: work out the frame events it owes
            if (s_tvalid && s_tready) begin
                req.action     = s_tuser;
                req.address    = s_tdata[15:0];
                req.data       = s_tdata[23:16];
                req.read_count = s_tdata[39:24];
                req.last_byte  = s_tlast;
                predict_frames(eeprom_shadow, req, frames);
                foreach (frames[i]) expected_frames.push_back(frames[i]);
                reqs_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------

    initial begin : run
        int idle_src[4];
        int idle_sink[4];
        clear_state(eeprom_shadow);
        clear_state(plan_shadow);
        // traffic phases: no idling, sender idle, receiver stalling, both
        idle_src  = '{0, 77, 0, 23};
        idle_sink = '{0, 0, 77, 23};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part
        queue_req(ACT_WAKE, 16'h0000, 8'h00, 1'b0, 16'h0000);
        queue_req(ACT_DEVICE, 16'h0000, 8'h5A, 1'b0, 16'h0000);  // device byte in idle
        queue_req(ACT_SPARE_HI, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF);
        queue_req(ACT_SPARE_LO, 16'h0000, 8'h00, 1'b0, 16'h0000);
        // write that wraps the address and pauses on the page boundary
        queue_req(ACT_WRITE, 16'hFFFE, 8'hFF, 1'b0, 16'h0000);
        queue_req(ACT_WRITE, 16'h0000, 8'h00, 1'b0, 16'h0000);  // write while polling
        queue_req(ACT_DEVICE, 16'h0000, 8'hFF, 1'b0, 16'h0000); // busy, poll again
        queue_req(ACT_DEVICE, 16'h0000, 8'h00, 1'b0, 16'h0000); // ready
        queue_req(ACT_WRITE, 16'h0000, 8'h00, 1'b0, 16'h0000);  // hits 0x0000, pauses
        queue_req(ACT_READ, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF);   // read while paused
        // resumed stream ignores the address field
        queue_req(ACT_WRITE, 16'h1234, 8'hA5, 1'b1, 16'h0000);
        queue_req(ACT_DEVICE, 16'h0000, 8'hFE, 1'b0, 16'h0000);
        // read of zero bytes
        queue_req(ACT_READ, 16'hFFFF, 8'h00, 1'b0, 16'h0000);
        queue_req(ACT_DEVICE, 16'h0000, 8'h00, 1'b0, 16'h0000);
        // two byte read with wrong-phase items on the way
        queue_req(ACT_READ, 16'h8001, 8'h00, 1'b0, 16'h0002);
        queue_req(ACT_SLEEP, 16'h0000, 8'h00, 1'b0, 16'h0000);
        queue_req(ACT_DEVICE, 16'h0000, 8'h01, 1'b0, 16'h0000);
        queue_req(ACT_DEVICE, 16'h0000, 8'h00, 1'b0, 16'h0000);
        queue_req(ACT_WRITE, 16'h0000, 8'h00, 1'b0, 16'h0000);
        queue_req(ACT_WAKE, 16'h0000, 8'h00, 1'b0, 16'h0000);
        queue_req(ACT_DEVICE, 16'h0000, 8'hFF, 1'b0, 16'h0000);
        queue_req(ACT_DEVICE, 16'h0000, 8'h00, 1'b0, 16'h0000);
        // sleep
        queue_req(ACT_SLEEP, 16'h0000, 8'h00, 1'b0, 16'h0000);
        queue_req(ACT_DEVICE, 16'h0000, 8'h00, 1'b0, 16'h0000);

        // random part; between phases the sender holds off until every
        // expected event is back
        for (int p = 0; p < 4; p++) begin
            while (reqs_accepted != reqs_queued || expected_frames.size() != 0)
                @(posedge aclk);
            src_idle_pct   = idle_src[p];
            sink_stall_pct = idle_sink[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) queue_random_req();
        end

        while (reqs_accepted != reqs_queued || expected_frames.size() != 0)
            @(posedge aclk);
        sink_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_frames.size() != 0)
            report_mismatch("events never delivered, count", expected_frames.size(), 0);

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
